// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the depth-tested pixel store.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed: implication violated");

// The condition must never be true.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: forbidden condition seen");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== rtl/dtps_pkg.sv =====
// Package with sizes, codes, background values and a clamping helper of the pixel store.
`timescale 1ns / 1ps

package dtps_pkg;

    // Frame geometry.
    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int PIXEL_COUNT = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int CNT_W       = $clog2(PIXEL_COUNT + 1);

    // Field widths.
    localparam int SIZE_W    = 9;
    localparam int OP_W      = 2;
    localparam int COORD_W   = 16;
    localparam int CHAN_IN_W = 16;
    localparam int CHAN_W    = 12;
    localparam int ALPHA_W   = 16;
    localparam int DEPTH_W   = 32;
    localparam int COLOR_W   = 3 * CHAN_W;
    localparam int AD_W      = ALPHA_W + DEPTH_W;
    localparam int CFG_IDX_W = 1;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_WRITE = OP_W'(0);
    localparam logic [OP_W-1:0] OP_READ  = OP_W'(1);
    localparam logic [OP_W-1:0] OP_CLEAR = OP_W'(2);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);
    localparam logic [SIZE_W-1:0]    SIZE_RESET       = SIZE_W'(256);

    // Background pixel.
    localparam logic [CHAN_W-1:0]  INTENSITY_MAX = CHAN_W'(4095);
    localparam logic [CHAN_W-1:0]  BG_BLUE       = CHAN_W'(1000);
    localparam logic [ALPHA_W-1:0] BG_ALPHA      = ALPHA_W'(1);
    localparam logic [DEPTH_W-1:0] BG_DEPTH      = 32'h7FFF_FFFF;
    localparam logic [COLOR_W-1:0] BG_COLOR      = {CHAN_W'(0), CHAN_W'(0), BG_BLUE};
    localparam logic [AD_W-1:0]    BG_AD         = {BG_ALPHA, BG_DEPTH};

    // Clamp a signed intensity to the range 0..4095.
    function automatic logic [CHAN_W-1:0] clamp_intensity(
        input logic signed [CHAN_IN_W-1:0] v
    );
        logic [CHAN_W-1:0] r;
        if (v[CHAN_IN_W-1])
            r = '0;
        else if (v[CHAN_IN_W-2:0] > (CHAN_IN_W-1)'(INTENSITY_MAX))
            r = INTENSITY_MAX;
        else
            r = v[CHAN_W-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/dtps_in_if.sv =====
// Request channel: one pixel operation per item.
`timescale 1ns / 1ps

interface dtps_in_if;
    import dtps_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [OP_W-1:0]             operation;
    logic signed [COORD_W-1:0]   column;
    logic signed [COORD_W-1:0]   row;
    logic signed [CHAN_IN_W-1:0] red_in;
    logic signed [CHAN_IN_W-1:0] green_in;
    logic signed [CHAN_IN_W-1:0] blue_in;
    logic signed [ALPHA_W-1:0]   alpha_in;
    logic signed [DEPTH_W-1:0]   depth_in;

    modport source (
        output valid, operation, column, row, red_in, green_in, blue_in,
               alpha_in, depth_in,
        input  ready
    );

    modport sink (
        input  valid, operation, column, row, red_in, green_in, blue_in,
               alpha_in, depth_in,
        output ready
    );
endinterface

// ===== rtl/dtps_out_if.sv =====
// Response channel: status and pixel data of one operation per item.
`timescale 1ns / 1ps

interface dtps_out_if;
    import dtps_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      status;
    logic [CHAN_W-1:0]         red_out;
    logic [CHAN_W-1:0]         green_out;
    logic [CHAN_W-1:0]         blue_out;
    logic signed [ALPHA_W-1:0] alpha_out;
    logic signed [DEPTH_W-1:0] depth_out;

    modport source (
        output valid, status, red_out, green_out, blue_out, alpha_out, depth_out,
        input  ready
    );

    modport sink (
        input  valid, status, red_out, green_out, blue_out, alpha_out, depth_out,
        output ready
    );
endinterface

// ===== rtl/dtps_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module dtps_ram #(
    parameter int DATA_W = 36,
    parameter int ADDR_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);
    logic [DATA_W-1:0] mem [2**ADDR_W];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end
endmodule

// ===== rtl/depth_tested_pixel_store.sv =====
// Top level of the depth-tested pixel store.
//
// Usage:
//   request carries one item per operation: write with depth test, read of a
//   pixel, or clear of the frame in use. response returns exactly one item per
//   request: status 1 for a coordinate outside the frame, and the stored pixel
//   on a successful read. The user must set the frame size through cfg_write,
//   cfg_index and cfg_data only while the block is idle; it does not enforce this.
//   Operation flow: a write or read is looked up in the pixel memories
//   at the edge that accepts it; the depth test and the result follow in the
//   S_DONE state, which writes the output register once it is free, and no new
//   item is taken until that result is registered.
//   A clear writes one pixel per cycle in S_CLEAR, then passes to S_DONE for
//   its result; no new item is taken until that result is registered.
//   Reset: the block sweeps every one of the 65536 pixel locations to the
//   background (blue 1000, alpha 1, maximum depth), one per cycle, and holds
//   request.ready low until the sweep ends; frame size resets to 256 x 256.
//   Stall: a finished result sits in the output register until taken; while a
//   second result waits for that register, request.ready stays low.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module depth_tested_pixel_store (
    input  logic                             clk,
    input  logic                             rst_n,
    dtps_in_if.sink                          request,
    dtps_out_if.source                       response,
    input  logic                             cfg_write,
    input  logic [dtps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dtps_pkg::SIZE_W-1:0]      cfg_data
);
    import dtps_pkg::*;

    localparam int SUM_W = 2 * SIZE_W + 1;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [SIZE_W-1:0] frame_width_reg;
    logic [SIZE_W-1:0] frame_height_reg;

    logic [CNT_W-1:0] sweep_idx_reg, sweep_idx_next;
    logic [CNT_W-1:0] sweep_end_reg, sweep_end_next;
    logic             outside_reg, outside_next;

    // Captured item.
    logic [OP_W-1:0]           op_reg;
    logic [ADDR_W-1:0]         addr_reg;
    logic [COLOR_W-1:0]        color_reg;
    logic [ALPHA_W-1:0]        alpha_reg;
    logic signed [DEPTH_W-1:0] depth_reg;

    // Output register.
    logic                      resp_valid_reg, resp_valid_next;
    logic                      status_reg;
    logic [CHAN_W-1:0]         red_reg;
    logic [CHAN_W-1:0]         green_reg;
    logic [CHAN_W-1:0]         blue_reg;
    logic signed [ALPHA_W-1:0] alpha_out_reg;
    logic signed [DEPTH_W-1:0] depth_out_reg;

    logic [SIZE_W-1:0]   w_use;
    logic [SIZE_W-1:0]   h_use;
    logic                col_ok;
    logic                row_ok;
    logic [2*SIZE_W-1:0] row_offset;
    logic [SUM_W-1:0]    addr_sum;
    logic [ADDR_W-1:0]   pix_addr;
    logic [2*SIZE_W-1:0] area;
    logic [CNT_W-1:0]    clear_count;
    logic                accept;
    logic                access;
    logic                sweep_last;
    logic                slot_free;
    logic                done_fire;
    logic                nearer;
    logic                write_hit;
    logic                show_data;

    logic                      ram_we;
    logic                      ram_re;
    logic [ADDR_W-1:0]         ram_waddr;
    logic [COLOR_W-1:0]        color_wdata;
    logic [AD_W-1:0]           ad_wdata;
    logic [COLOR_W-1:0]        color_rdata;
    logic [AD_W-1:0]           ad_rdata;
    logic signed [DEPTH_W-1:0] rd_depth;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= SIZE_RESET;
            frame_height_reg <= SIZE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Frame size in use, capped at the maximum.
    assign w_use = (32'(frame_width_reg) > MAX_WIDTH) ? SIZE_W'(MAX_WIDTH) : frame_width_reg;
    assign h_use = (32'(frame_height_reg) > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT)
                                                         : frame_height_reg;

    // Coordinate check and pixel address.
    assign col_ok = !request.column[COORD_W-1]
                    && (32'(request.column[COORD_W-2:0]) < 32'(w_use));
    assign row_ok = !request.row[COORD_W-1]
                    && (32'(request.row[COORD_W-2:0]) < 32'(h_use));
    assign row_offset = (2*SIZE_W)'(request.row[SIZE_W-1:0]) * (2*SIZE_W)'(w_use);
    assign addr_sum   = SUM_W'(row_offset) + SUM_W'(request.column[SIZE_W-1:0]);
    assign pix_addr   = ADDR_W'(addr_sum);
    assign area        = (2*SIZE_W)'(w_use) * (2*SIZE_W)'(h_use);
    assign clear_count = CNT_W'(area);

    // Handshake and control terms.
    assign request.ready = (state_reg == S_IDLE);
    assign accept        = request.valid && request.ready;
    assign access        = ((request.operation == OP_WRITE) || (request.operation == OP_READ))
                           && col_ok && row_ok;
    assign sweep_last    = (sweep_idx_reg + CNT_W'(1)) == sweep_end_reg;
    assign slot_free     = !resp_valid_reg || response.ready;
    assign done_fire     = (state_reg == S_DONE) && slot_free;

    // Depth test against the stored pixel.
    assign rd_depth  = ad_rdata[DEPTH_W-1:0];
    assign nearer    = depth_reg < rd_depth;
    assign write_hit = (op_reg == OP_WRITE) && !outside_reg && nearer;
    assign show_data = (op_reg == OP_READ) && !outside_reg;

    // Memory port control: sweeps write background, the test stage writes back.
    always_comb
    begin
        ram_we      = 1'b0;
        ram_waddr   = addr_reg;
        color_wdata = color_reg;
        ad_wdata    = {alpha_reg, depth_reg};
        case (state_reg)
            S_INIT, S_CLEAR:
            begin
                ram_we      = 1'b1;
                ram_waddr   = sweep_idx_reg[ADDR_W-1:0];
                color_wdata = BG_COLOR;
                ad_wdata    = BG_AD;
            end
            S_DONE:
                ram_we = done_fire && write_hit;
            default: ;
        endcase
    end

    assign ram_re = accept && access;

    dtps_ram #(
        .DATA_W (COLOR_W),
        .ADDR_W (ADDR_W)
    ) u_color_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (color_wdata),
        .re    (ram_re),
        .raddr (pix_addr),
        .rdata (color_rdata)
    );

    dtps_ram #(
        .DATA_W (AD_W),
        .ADDR_W (ADDR_W)
    ) u_alpha_depth_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ad_wdata),
        .re    (ram_re),
        .raddr (pix_addr),
        .rdata (ad_rdata)
    );

    // Next state of the sequencer.
    always_comb
    begin
        state_next      = state_reg;
        sweep_idx_next  = sweep_idx_reg;
        sweep_end_next  = sweep_end_reg;
        outside_next    = outside_reg;
        resp_valid_next = resp_valid_reg && !response.ready;
        case (state_reg)
            S_INIT:
            begin
                sweep_idx_next = sweep_idx_reg + CNT_W'(1);
                if (sweep_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    outside_next = 1'b0;
                    state_next   = S_DONE;
                    case (request.operation)
                        OP_CLEAR:
                        begin
                            sweep_idx_next = '0;
                            sweep_end_next = clear_count;
                            if (clear_count != '0)
                                state_next = S_CLEAR;
                        end
                        OP_WRITE, OP_READ:
                            outside_next = !(col_ok && row_ok);
                        default: ;
                    endcase
                end
            end
            S_CLEAR:
            begin
                sweep_idx_next = sweep_idx_reg + CNT_W'(1);
                if (sweep_last)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    resp_valid_next = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // State, captured item and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            sweep_idx_reg  <= '0;
            sweep_end_reg  <= CNT_W'(PIXEL_COUNT);
            outside_reg    <= 1'b0;
            resp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_idx_reg  <= sweep_idx_next;
            sweep_end_reg  <= sweep_end_next;
            outside_reg    <= outside_next;
            resp_valid_reg <= resp_valid_next;
            if (accept)
            begin
                op_reg    <= request.operation;
                addr_reg  <= pix_addr;
                color_reg <= {clamp_intensity(request.red_in),
                              clamp_intensity(request.green_in),
                              clamp_intensity(request.blue_in)};
                alpha_reg <= request.alpha_in;
                depth_reg <= request.depth_in;
            end
            if (done_fire)
            begin
                status_reg    <= outside_reg;
                red_reg       <= show_data ? color_rdata[COLOR_W-1:2*CHAN_W] : '0;
                green_reg     <= show_data ? color_rdata[2*CHAN_W-1:CHAN_W] : '0;
                blue_reg      <= show_data ? color_rdata[CHAN_W-1:0] : '0;
                alpha_out_reg <= show_data ? ad_rdata[AD_W-1:DEPTH_W] : '0;
                depth_out_reg <= show_data ? rd_depth : '0;
            end
        end
    end

    assign response.valid     = resp_valid_reg;
    assign response.status    = status_reg;
    assign response.red_out   = red_reg;
    assign response.green_out = green_reg;
    assign response.blue_out  = blue_reg;
    assign response.alpha_out = alpha_out_reg;
    assign response.depth_out = depth_out_reg;

    // A pixel is never written while the block waits for an item.
    `ASSERT_NEVER(a_no_write_idle, clk, rst_n, ram_we && (state_reg == S_IDLE))
    // A lookup and a write-back never share a cycle, so no forwarding is needed.
    `ASSERT_NEVER(a_no_rd_wr_overlap, clk, rst_n, ram_re && ram_we)
    // A new result only comes out of the depth test stage.
    `ASSERT_IMPLIES(a_result_from_done, clk, rst_n, $rose(resp_valid_reg),
                    $past(state_reg) == S_DONE)
    // Sweeps stay inside the range they were started with.
    `ASSERT_IMPLIES(a_sweep_in_range, clk, rst_n,
                    (state_reg == S_INIT) || (state_reg == S_CLEAR),
                    sweep_idx_reg < sweep_end_reg)
endmodule
